### src/lbps_pkg.sv
// lbps_pkg: shared types, constants and helper functions for the led pattern sequencer
// used by lbps_store, lbps_core, led_blink_pattern_sequencer and lbps_checker
// no dependencies
package lbps_pkg;

    // table geometry
    localparam int PATTERN_LEN = 32;
    localparam int IDX_W       = $clog2(PATTERN_LEN);
    localparam int ADDR_W      = IDX_W + 1;
    localparam int MEM_DEPTH   = 2 ** ADDR_W;

    // fixed field widths
    localparam int ENTRY_W     = 16;
    localparam int ENTRY_IDX_W = 5;
    localparam int TUSER_W     = 2;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    // default pattern contents
    localparam int ALARM_LEN   = 18;
    localparam int NORMAL_LEN  = 2;

    typedef logic [ENTRY_W-1:0] t_entry;
    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [ADDR_W-1:0]  t_addr;

    localparam t_entry NORMAL_DUR = 16'd500;
    localparam t_entry ALARM_INIT [ALARM_LEN] = '{
        16'd200, 16'd100, 16'd200, 16'd100, 16'd200, 16'd100,
        16'd500, 16'd100, 16'd500, 16'd100, 16'd500, 16'd100,
        16'd200, 16'd100, 16'd200, 16'd100, 16'd200, 16'd500
    };

    typedef enum logic [TUSER_W-1:0] {
        ACT_TICK  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_READ  = 2'd2
    } t_action;

    typedef struct packed {
        t_action                action;
        logic                   pin_level;
        logic                   table_select;
        logic [ENTRY_IDX_W-1:0] entry_index;
        t_entry                 entry_value;
    } t_item;

    typedef struct packed {
        t_entry read_data;
        logic   active_pattern;
        logic   led_on;
    } t_result;

    typedef struct packed {
        logic   en;
        t_addr  addr;
        t_entry data;
    } t_wr_req;

    localparam int RES_W = $bits(t_result);

    // reset content of one store entry, upper address bit picks the table
    function automatic t_entry init_entry(input t_addr a);
        t_idx   i;
        t_entry v;
        i = a[IDX_W-1:0];
        v = '0;
        if (a[ADDR_W-1]) begin
            if (32'(i) < ALARM_LEN) begin
                v = ALARM_INIT[i[4:0]];
            end
        end else begin
            if (32'(i) < NORMAL_LEN) begin
                v = NORMAL_DUR;
            end
        end
        return v;
    endfunction

    // step index advance with wrap at table end
    function automatic t_idx next_idx(input t_idx s);
        t_idx r;
        if (s == IDX_W'(PATTERN_LEN - 1)) begin
            r = '0;
        end else begin
            r = s + 1'b1;
        end
        return r;
    endfunction

    // store address of an entry given by the request fields
    function automatic t_addr item_addr(input logic tsel,
                                        input logic [ENTRY_IDX_W-1:0] idx);
        return {tsel, IDX_W'(idx)};
    endfunction

    function automatic logic idx_in_range(input logic [ENTRY_IDX_W-1:0] idx);
        return (32'(idx) < PATTERN_LEN);
    endfunction

endpackage

### src/lbps_store.sv
// lbps_store: pattern table memory with per-entry valid bits over the default contents
// one write port, a prefetch read port and a request read port, plus entry 0 of each table
// depends on lbps_pkg
module lbps_store (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lbps_pkg::t_wr_req i_wr,
    input  lbps_pkg::t_addr i_a_addr,
    input  logic            i_b_en,
    input  lbps_pkg::t_addr i_b_addr,
    output lbps_pkg::t_entry o_a_data,
    output lbps_pkg::t_entry o_b_data,
    output lbps_pkg::t_entry o_head_normal,
    output lbps_pkg::t_entry o_head_alarm
);

    lbps_pkg::t_entry r_mem [lbps_pkg::MEM_DEPTH];
    logic [lbps_pkg::MEM_DEPTH-1:0] r_vld;

    lbps_pkg::t_entry r_a_mem, r_a_fdata, r_b_mem, r_b_fdata;
    lbps_pkg::t_addr  r_a_addr, r_b_addr;
    logic             r_a_vld, r_a_fwd, r_b_vld, r_b_fwd;
    lbps_pkg::t_entry r_head_normal, r_head_alarm;

    logic a_hit, b_hit;

    assign a_hit = i_wr.en && (i_wr.addr == i_a_addr);
    assign b_hit = i_wr.en && (i_wr.addr == i_b_addr);

    // memory write and registered reads
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_a_mem   <= r_mem[i_a_addr];
        r_a_addr  <= i_a_addr;
        r_a_fdata <= i_wr.data;
        if (i_b_en) begin
            r_b_mem   <= r_mem[i_b_addr];
            r_b_addr  <= i_b_addr;
            r_b_fdata <= i_wr.data;
        end
    end

    // valid bits, forward flags and table heads
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld         <= '0;
            r_a_vld       <= 1'b0;
            r_a_fwd       <= 1'b0;
            r_b_vld       <= 1'b0;
            r_b_fwd       <= 1'b0;
            r_head_normal <= lbps_pkg::init_entry('0);
            r_head_alarm  <= lbps_pkg::init_entry({1'b1, lbps_pkg::IDX_W'(0)});
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr.addr] <= 1'b1;
                if (i_wr.addr[lbps_pkg::IDX_W-1:0] == '0) begin
                    if (i_wr.addr[lbps_pkg::ADDR_W-1]) begin
                        r_head_alarm <= i_wr.data;
                    end else begin
                        r_head_normal <= i_wr.data;
                    end
                end
            end
            r_a_vld <= r_vld[i_a_addr];
            r_a_fwd <= a_hit;
            if (i_b_en) begin
                r_b_vld <= r_vld[i_b_addr];
                r_b_fwd <= b_hit;
            end
        end
    end

    // entries never written read as their default
    assign o_a_data = r_a_fwd ? r_a_fdata :
                      r_a_vld ? r_a_mem : lbps_pkg::init_entry(r_a_addr);
    assign o_b_data = r_b_fwd ? r_b_fdata :
                      r_b_vld ? r_b_mem : lbps_pkg::init_entry(r_b_addr);

    assign o_head_normal = r_head_normal;
    assign o_head_alarm  = r_head_alarm;

endmodule

### src/lbps_core.sv
// lbps_core: sequencer state, tick and table request handling, result register
// depends on lbps_pkg
module lbps_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lbps_pkg::t_item   i_item,
    input  logic              i_fire,
    input  lbps_pkg::t_entry  i_cur,
    input  lbps_pkg::t_entry  i_rd_entry,
    input  lbps_pkg::t_entry  i_head_normal,
    input  lbps_pkg::t_entry  i_head_alarm,
    output lbps_pkg::t_wr_req o_wr,
    output lbps_pkg::t_addr   o_a_addr,
    output lbps_pkg::t_result o_res
);

    lbps_pkg::t_idx    r_step, n_step;
    lbps_pkg::t_entry  r_delay, n_delay;
    logic              r_mode, n_mode;
    logic              r_last, n_last;
    logic              r_led, n_led;
    lbps_pkg::t_result r_res;

    lbps_pkg::t_idx   step0;
    lbps_pkg::t_entry load_val;
    lbps_pkg::t_entry rd;
    logic             idx_ok;

    assign idx_ok = lbps_pkg::idx_in_range(i_item.entry_index);

    // next state for the item in the input register
    always_comb begin
        n_step   = r_step;
        n_delay  = r_delay;
        n_mode   = r_mode;
        n_last   = r_last;
        n_led    = r_led;
        step0    = r_step;
        load_val = i_cur;
        rd       = '0;
        unique case (i_item.action)
            lbps_pkg::ACT_TICK: begin
                if (r_delay != '0) begin
                    n_delay = r_delay - 1'b1;
                end else begin
                    // zero entry ends the pattern, restart from entry 0
                    if (i_cur == '0) begin
                        step0    = '0;
                        load_val = r_mode ? i_head_alarm : i_head_normal;
                    end
                    n_led   = ~step0[0];
                    n_delay = load_val;
                    n_step  = lbps_pkg::next_idx(step0);
                end
                // pin change switches pattern, led left alone
                if (i_item.pin_level != r_last) begin
                    n_mode  = ~i_item.pin_level;
                    n_step  = lbps_pkg::next_idx('0);
                    n_delay = i_item.pin_level ? i_head_normal : i_head_alarm;
                    n_last  = i_item.pin_level;
                end
            end
            lbps_pkg::ACT_READ: begin
                if (idx_ok) begin
                    rd = i_rd_entry;
                end
            end
            default: begin
            end
        endcase
    end

    // table write request
    always_comb begin
        o_wr.en   = i_fire && (i_item.action == lbps_pkg::ACT_WRITE) && idx_ok;
        o_wr.addr = lbps_pkg::item_addr(i_item.table_select, i_item.entry_index);
        o_wr.data = i_item.entry_value;
    end

    // prefetch address of the current pattern entry
    assign o_a_addr = i_fire ? {n_mode, n_step} : {r_mode, r_step};

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_delay <= '0;
            r_mode  <= 1'b0;
            r_last  <= 1'b0;
            r_led   <= 1'b0;
        end else if (i_fire) begin
            r_step  <= n_step;
            r_delay <= n_delay;
            r_mode  <= n_mode;
            r_last  <= n_last;
            r_led   <= n_led;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_res.led_on         <= n_led;
            r_res.active_pattern <= n_mode;
            r_res.read_data      <= rd;
        end
    end

    assign o_res = r_res;

endmodule

### src/led_blink_pattern_sequencer.sv
// led_blink_pattern_sequencer: top level, stream handshake, input and output registers
// depends on lbps_pkg, lbps_store, lbps_core
//
// Usage: every request on the slave stream produces exactly one result on the master
// stream. The request kind sits in i_s_tuser: tick with pin sample, table write or
// table read. A tick counts the current duration down and, when it has run out, steps
// the LED to the next pattern entry; a change of the sampled pin switches between the
// normal and the alarm pattern and restarts it. Writes and reads reach any entry of
// either table; a read returns the entry as read_data, all other requests give read_data 0.
// Pipeline: a taken request is held in the input register, its result in the result
// register. Throughput: one request per cycle unless the output stalls, bounded by the
// single registered read of the pattern memory that prefetches the current entry.
// Reset: state clears and both tables read as their default patterns at once, since a
// valid bit per entry covers the memory; requests are taken right after reset.
// Stall: a held result stays on o_m_tdata; one more request is held in the input
// register, after which o_s_tready drops until the result is taken.
module led_blink_pattern_sequencer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // tdata: pin_level, table_select, entry_index[4:0], entry_value[15:0], zero pad
    input  logic [lbps_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    // tuser: action[1:0]
    input  logic [lbps_pkg::TUSER_W-1:0]      i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // tdata: led_on, active_pattern, read_data[15:0], zero pad
    output logic [lbps_pkg::OUT_TDATA_W-1:0]  o_m_tdata
);

    lbps_pkg::t_item   in_item, r_item;
    logic              r_iv, r_ov;
    logic              adv, fire, accept;
    lbps_pkg::t_wr_req wr;
    lbps_pkg::t_addr   a_addr;
    lbps_pkg::t_entry  a_data, b_data, head_normal, head_alarm;
    lbps_pkg::t_result res;

    // unpack request
    always_comb begin
        in_item.action       = lbps_pkg::t_action'(i_s_tuser);
        in_item.pin_level    = i_s_tdata[0];
        in_item.table_select = i_s_tdata[1];
        in_item.entry_index  = i_s_tdata[6:2];
        in_item.entry_value  = i_s_tdata[22:7];
    end

    // handshake
    assign adv        = !r_ov || i_m_tready;
    assign fire       = r_iv && adv;
    assign o_s_tready = !r_iv || adv;
    assign accept     = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_iv <= i_s_tvalid;
            end
            if (adv) begin
                r_ov <= r_iv;
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= in_item;
        end
    end

    lbps_store u_store (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_wr          (wr),
        .i_a_addr      (a_addr),
        .i_b_en        (accept),
        .i_b_addr      (lbps_pkg::item_addr(in_item.table_select, in_item.entry_index)),
        .o_a_data      (a_data),
        .o_b_data      (b_data),
        .o_head_normal (head_normal),
        .o_head_alarm  (head_alarm)
    );

    lbps_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (r_item),
        .i_fire        (fire),
        .i_cur         (a_data),
        .i_rd_entry    (b_data),
        .i_head_normal (head_normal),
        .i_head_alarm  (head_alarm),
        .o_wr          (wr),
        .o_a_addr      (a_addr),
        .o_res         (res)
    );

    // pack result
    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {(lbps_pkg::OUT_TDATA_W - lbps_pkg::RES_W)'(0), res};

endmodule

### src/lbps_checker.sv
// lbps_checker: port level checks for led_blink_pattern_sequencer, bound to the top level
// depends on lbps_pkg
module lbps_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_tvalid,
    input logic                              o_s_tready,
    input logic [lbps_pkg::TUSER_W-1:0]      i_s_tuser,
    input logic                              o_m_tvalid,
    input logic                              i_m_tready,
    input logic [lbps_pkg::OUT_TDATA_W-1:0]  o_m_tdata
);

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // a held result keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    // an empty output side never blocks requests
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("request blocked with empty output");

    // only a read request returns table data
    a_no_read_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && (i_s_tuser != lbps_pkg::ACT_READ))
        ##1 (!o_m_tvalid || i_m_tready)
        |=> o_m_tvalid && (o_m_tdata[17:2] == 16'd0))
        else $error("read data on non-read result");

endmodule

bind led_blink_pattern_sequencer lbps_checker u_lbps_checker (.*);
